// ----- rtl/irl_pkg.sv -----
// ----------------------------------------------------------------------------
// irl_pkg
// Shared types and codes for the indexed insert/remove list.
// ----------------------------------------------------------------------------
package irl_pkg;

    localparam int DEFAULT_CAPACITY = 16;

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_FILL   = 3'd4;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_INDEX = 2'd1;
    localparam logic [1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic [4:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         error;
        logic [4:0]         length_now;
    } rsp_t;

    // Command broadcast to every cell; already checked for a legal index
    typedef struct packed {
        logic wr;
        logic ins;
        logic rem;
        logic fill;
    } cell_cmd_t;

endpackage

// ----- rtl/irl_req_if.sv -----
// ----------------------------------------------------------------------------
// irl_req_if
// Request channel: valid/ready handshake with a request payload.
// ----------------------------------------------------------------------------
interface irl_req_if;
    logic          valid;
    logic          ready;
    irl_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/irl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// irl_rsp_if
// Response channel: valid/ready handshake with a response payload.
// ----------------------------------------------------------------------------
interface irl_rsp_if;
    logic          valid;
    logic          ready;
    irl_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/indexed_insert_remove_list_core.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core
// Ordered list of signed 32-bit entries kept in a row of shifting cells.
//
//   channel | role   | payload
//   --------+--------+------------------------------------
//   req     | sink   | operation, position, value
//   rsp     | source | read_data, error, length_now
//
// One transaction per cycle: every cell loads from its neighbour in parallel,
// so an insert or remove completes in the cycle it is accepted.
// The response appears in the cycle after acceptance, in an output register;
// a new request is taken whenever that register is empty or being drained.
// Reset clears the length; entry contents are undefined until written.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core #(
    parameter int CAPACITY = irl_pkg::DEFAULT_CAPACITY
) (
    input  logic     clk,
    input  logic     rst_n,
    irl_req_if.sink  req,
    irl_rsp_if.source rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [CW-1:0]       used_reg;
    logic [CW-1:0]       used_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    irl_pkg::rsp_t       rsp_reg;
    irl_pkg::rsp_t       rsp_next;

    logic                accept;
    logic [CW+4:0]       pos_w;
    logic [CW+4:0]       used_w;
    logic [CW+4:0]       len_w;
    logic [CW-1:0]       pos_c;
    logic [IW-1:0]       pos_i;
    logic                idx_ok;
    logic                ins_ok;
    logic                full;
    irl_pkg::cell_cmd_t  cmd;
    logic signed [31:0]  rdata;
    logic [1:0]          err;

    logic signed [31:0]  cell_data [CAPACITY];

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign pos_w  = {CW'(0), req.payload.position};
    assign used_w = {5'd0, used_reg};
    assign pos_c  = pos_w[CW-1:0];
    assign pos_i  = pos_w[IW-1:0];
    assign idx_ok = pos_w < used_w;
    assign ins_ok = pos_w <= used_w;
    assign full   = used_reg == CW'(CAPACITY);

    always_comb
    begin
        cmd       = '0;
        rdata     = '0;
        err       = irl_pkg::ERR_OK;
        used_next = used_reg;
        case (req.payload.operation)
            irl_pkg::OP_READ:
            begin
                if (idx_ok)
                begin
                    rdata = cell_data[pos_i];
                end
                else
                begin
                    rdata = -32'sd1;
                    err   = irl_pkg::ERR_INDEX;
                end
            end
            irl_pkg::OP_WRITE:
            begin
                if (idx_ok)
                begin
                    cmd.wr = 1'b1;
                end
                else
                begin
                    err = irl_pkg::ERR_INDEX;
                end
            end
            irl_pkg::OP_INSERT:
            begin
                if (!ins_ok)
                begin
                    err = irl_pkg::ERR_INDEX;
                end
                else if (full)
                begin
                    err = irl_pkg::ERR_FULL;
                end
                else
                begin
                    cmd.ins   = 1'b1;
                    used_next = used_reg + CW'(1);
                end
            end
            irl_pkg::OP_REMOVE:
            begin
                if (idx_ok)
                begin
                    cmd.rem   = 1'b1;
                    used_next = used_reg - CW'(1);
                end
                else
                begin
                    err = irl_pkg::ERR_INDEX;
                end
            end
            irl_pkg::OP_FILL:
            begin
                cmd.fill = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
        if (!accept)
        begin
            cmd       = '0;
            used_next = used_reg;
        end
    end

    assign len_w = {5'd0, used_next};

    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.read_data  = rdata;
            rsp_next.error      = err;
            rsp_next.length_now = len_w[4:0];
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [31:0] left_d;
            logic signed [31:0] right_d;
            if (i == 0)
            begin : g_first
                assign left_d = req.payload.value;
            end
            else
            begin : g_left
                assign left_d = cell_data[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[i];
            end
            else
            begin : g_right
                assign right_d = cell_data[i+1];
            end
            irl_cell #(
                .CW    (CW),
                .INDEX (i)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .pos        (pos_c),
                .used       (used_reg),
                .value      (req.payload.value),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

endmodule

// ----- rtl/irl_cell.sv -----
// ----------------------------------------------------------------------------
// irl_cell
// One list entry: holds, loads, or takes the value of a neighbour.
// ----------------------------------------------------------------------------
module irl_cell #(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic                  clk,
    input  irl_pkg::cell_cmd_t    cmd,
    input  logic [CW-1:0]         pos,
    input  logic [CW-1:0]         used,
    input  logic signed [31:0]    value,
    input  logic signed [31:0]    left_data,
    input  logic signed [31:0]    right_data,
    output logic signed [31:0]    data
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.wr && (IDX == pos))
        begin
            data_next = value;
        end
        else if (cmd.ins)
        begin
            if (IDX == pos)
            begin
                data_next = value;
            end
            else if (IDX > pos)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.rem && (IDX >= pos))
        begin
            data_next = right_data;
        end
        else if (cmd.fill && (IDX < used))
        begin
            data_next = value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- bench/indexed_insert_remove_list_core_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_core_tb
// Self-checking bench for the indexed insert/remove list. A directed table
// walks the empty list, the field extremes, every operation, a full list and
// bad indexes. Random grow and shrink phases follow, with some noise mixed in.
// A behavioural list predicts each unpinned response; both channels idle at
// random. One long response hold-off backs up the request channel.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_core_tb;

    localparam int LIST_CAPACITY = irl_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS  = 600;
    localparam int HOLD_AT_RSP   = 150;
    localparam int HOLD_CYCLES   = 80;

    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        irl_pkg::req_t rq;
        int            reps;
        bit            pinned;
        irl_pkg::rsp_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    irl_req_if req_if();
    irl_rsp_if rsp_if();

    indexed_insert_remove_list_core #(
        .CAPACITY (LIST_CAPACITY)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    logic signed [31:0] list_entries [LIST_CAPACITY];
    int                 list_len;
    bit                 grow_phase;
    bit                 burst_mode;

    irl_pkg::rsp_t pending_rsp_q [$];
    dir_row_t      dir_rows [$];

    int mismatch_count;
    int rsp_checked;
    int max_len_seen;
    int op_count [8];
    int err_count [4];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    function automatic irl_pkg::rsp_t apply_list_request(input irl_pkg::req_t r);
        irl_pkg::rsp_t o;
        int            p;
        int            i;
        o = '0;
        p = r.position;
        case (r.operation)
            irl_pkg::OP_READ:
                if (p < list_len)
                    o.read_data = list_entries[p];
                else
                begin
                    o.read_data = -32'sd1;
                    o.error     = irl_pkg::ERR_INDEX;
                end
            irl_pkg::OP_WRITE:
                if (p < list_len)
                    list_entries[p] = r.value;
                else
                    o.error = irl_pkg::ERR_INDEX;
            irl_pkg::OP_INSERT:
                if (p > list_len)
                    o.error = irl_pkg::ERR_INDEX;
                else if (list_len >= LIST_CAPACITY)
                    o.error = irl_pkg::ERR_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_entries[i] = list_entries[i - 1];
                    list_entries[p] = r.value;
                    list_len++;
                end
            irl_pkg::OP_REMOVE:
                if (p < list_len)
                begin
                    for (i = p; i + 1 < list_len; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_len--;
                end
                else
                    o.error = irl_pkg::ERR_INDEX;
            irl_pkg::OP_FILL:
                for (i = 0; i < list_len; i++)
                    list_entries[i] = r.value;
            default:
                ;
        endcase
        o.length_now = 5'(list_len);
        return o;
    endfunction

    function automatic dir_row_t mk_row(input logic [2:0] op, input logic [4:0] pos,
                                        input logic [31:0] val, input int reps,
                                        input bit pinned, input logic [31:0] rd,
                                        input logic [1:0] er, input logic [4:0] ln);
        dir_row_t d;
        d.rq.operation   = op;
        d.rq.position    = pos;
        d.rq.value       = val;
        d.reps           = reps;
        d.pinned         = pinned;
        d.want.read_data = rd;
        d.want.error     = er;
        d.want.length_now = ln;
        return d;
    endfunction

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic irl_pkg::req_t draw_list_request();
        irl_pkg::req_t r;
        int            k;
        r.value = draw_value();
        if ($urandom_range(0, 9) == 0)
        begin
            r.operation = 3'($urandom_range(0, 7));
            r.position  = 5'($urandom_range(0, 31));
            return r;
        end
        if (list_len >= LIST_CAPACITY)
            grow_phase = 1'b0;
        else if (list_len == 0)
            grow_phase = 1'b1;
        k = $urandom_range(0, 99);
        if (k < 45)
            r.operation = grow_phase ? irl_pkg::OP_INSERT : irl_pkg::OP_REMOVE;
        else if (k < 55)
            r.operation = grow_phase ? irl_pkg::OP_REMOVE : irl_pkg::OP_INSERT;
        else if (k < 75)
            r.operation = irl_pkg::OP_READ;
        else if (k < 92)
            r.operation = irl_pkg::OP_WRITE;
        else
            r.operation = irl_pkg::OP_FILL;
        if (r.operation == irl_pkg::OP_INSERT)
            r.position = 5'($urandom_range(0, list_len));
        else if (list_len > 0)
            r.position = 5'($urandom_range(0, list_len - 1));
        else
            r.position = 5'($urandom_range(0, 31));
        return r;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("tb: mismatch, %s at response %0d: got %0h, want %0h",
                 what, rsp_checked, got, want);
    endtask

    task automatic send_request(input irl_pkg::req_t r, input bit pinned,
                                input irl_pkg::rsp_t want);
        int            gap;
        irl_pkg::rsp_t pred;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge clk);
        while (!req_if.ready);
        pred = apply_list_request(r);
        op_count[r.operation]++;
        err_count[pred.error]++;
        if (list_len > max_len_seen)
            max_len_seen = list_len;
        pending_rsp_q.push_back(pinned ? want : pred);
    endtask

    task automatic check_response(input irl_pkg::rsp_t got);
        irl_pkg::rsp_t want;
        if (pending_rsp_q.size() == 0)
        begin
            report_mismatch("unexpected transaction", got.read_data, 0);
            return;
        end
        want = pending_rsp_q.pop_front();
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
        if (got.error !== want.error)
            report_mismatch("error", 32'(got.error), 32'(want.error));
        if (got.length_now !== want.length_now)
            report_mismatch("length_now", 32'(got.length_now), 32'(want.length_now));
        rsp_checked++;
    endtask

    // Response side: random ready gaps, one long hold-off
    initial
    begin
        int gap;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (rsp_checked == HOLD_AT_RSP) ? HOLD_CYCLES : draw_gap();
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_if.valid);
            check_response(rsp_if.payload);
        end
    end

    initial
    begin
        irl_pkg::req_t r;
        irl_pkg::rsp_t none;
        int            n;
        int            idx;
        none           = '0;
        list_len       = 0;
        grow_phase     = 1'b1;
        burst_mode     = 1'b0;
        mismatch_count = 0;
        rsp_checked    = 0;
        max_len_seen   = 0;
        foreach (list_entries[i])
            list_entries[i] = '0;
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;

        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd0,  32'h0,         1, 1,
                                  32'hFFFF_FFFF, irl_pkg::ERR_INDEX, 5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_REMOVE, 5'd0,  32'h0,         1, 1,
                                  32'h0, irl_pkg::ERR_INDEX, 5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_FILL,   5'd31, 32'hFFFF_FFFF, 1, 1,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd1,  32'h1234_5678, 1, 1,
                                  32'h0, irl_pkg::ERR_INDEX, 5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd0,  32'h7FFF_FFFF, 1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd1,  32'h8000_0000, 1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd1,  32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd0,  32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd2,  32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd2,  32'hFFFF_FFFF, 13, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd16, 32'h5555_5555, 1, 1,
                                  32'h0, irl_pkg::ERR_FULL,  5'd16));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd17, 32'h5555_5555, 1, 1,
                                  32'h0, irl_pkg::ERR_INDEX, 5'd16));
        dir_rows.push_back(mk_row(irl_pkg::OP_INSERT, 5'd31, 32'hAAAA_AAAA, 1, 1,
                                  32'h0, irl_pkg::ERR_INDEX, 5'd16));
        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd31, 32'h0,         1, 1,
                                  32'hFFFF_FFFF, irl_pkg::ERR_INDEX, 5'd16));
        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd15, 32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_WRITE,  5'd15, 32'h8000_0000, 1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_WRITE,  5'd16, 32'h7FFF_FFFF, 1, 1,
                                  32'h0, irl_pkg::ERR_INDEX, 5'd16));
        dir_rows.push_back(mk_row(irl_pkg::OP_REMOVE, 5'd16, 32'h0,         1, 1,
                                  32'h0, irl_pkg::ERR_INDEX, 5'd16));
        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd15, 32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_REMOVE, 5'd15, 32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_REMOVE, 5'd0,  32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_FILL,   5'd3,  32'h5A5A_A5A5, 1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(OP_SPARE_7,         5'd31, 32'hFFFF_FFFF, 1, 1,
                                  32'h0, irl_pkg::ERR_OK,    5'd14));
        dir_rows.push_back(mk_row(OP_SPARE_5,         5'd0,  32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));
        dir_rows.push_back(mk_row(irl_pkg::OP_READ,   5'd13, 32'h0,         1, 0,
                                  32'h0, irl_pkg::ERR_OK,    5'd0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            for (n = 0; n < dir_rows[i].reps; n++)
                send_request(dir_rows[i].rq, dir_rows[i].pinned, dir_rows[i].want);

        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            burst_mode = (idx % 200) >= 150;
            r = draw_list_request();
            send_request(r, 1'b0, none);
        end
        burst_mode = 1'b0;
        req_if.valid <= 1'b0;

        n = 0;
        while (pending_rsp_q.size() > 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        if (pending_rsp_q.size() > 0)
            report_mismatch("responses never seen", pending_rsp_q.size(), 0);

        $display("tb: %0d responses checked; read %0d, write %0d, insert %0d,",
                 rsp_checked, op_count[irl_pkg::OP_READ], op_count[irl_pkg::OP_WRITE],
                 op_count[irl_pkg::OP_INSERT]);
        $display("tb: remove %0d, fill %0d, other %0d; bad index %0d, full list %0d,",
                 op_count[irl_pkg::OP_REMOVE], op_count[irl_pkg::OP_FILL],
                 op_count[OP_SPARE_5] + op_count[OP_SPARE_6] + op_count[OP_SPARE_7],
                 err_count[irl_pkg::ERR_INDEX], err_count[irl_pkg::ERR_FULL]);
        $display("tb: longest list %0d, mismatches %0d", max_len_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
